>>> hdl/sdfd_pkg.sv
// Shared types, constants and calendar helpers for the start date-time block.
package sdfd_pkg;

	// Only the low DURATION_BITS bits of the duration take part (17..32).
	localparam int DURATION_BITS = 32;
	localparam int DUR_IN_W      = 32;
	localparam int TOD_W         = 17;

	localparam logic [TOD_W-1:0] SECS_PER_DAY  = TOD_W'(86400);
	localparam logic [TOD_W-1:0] SECS_PER_HOUR = TOD_W'(3600);
	localparam logic [TOD_W-1:0] SECS_PER_MIN  = TOD_W'(60);

	localparam logic [7:0] MAX_YEAR   = 8'd99;
	localparam logic [7:0] MAX_MONTH  = 8'd12;
	localparam logic [7:0] MAX_HOUR   = 8'd23;
	localparam logic [7:0] MAX_MINSEC = 8'd59;
	localparam logic [7:0] FEBRUARY   = 8'd2;
	localparam logic [7:0] DECEMBER   = 8'd12;
	localparam logic [7:0] LEAP_FEB   = 8'd29;

	typedef struct packed {
		logic [7:0]          end_year;
		logic [7:0]          end_month;
		logic [7:0]          end_day;
		logic [7:0]          end_hour;
		logic [7:0]          end_minute;
		logic [7:0]          end_second;
		logic [DUR_IN_W-1:0] duration_seconds;
	} req_word_t;

	typedef struct packed {
		logic       valid_res;
		logic [6:0] start_year;
		logic [3:0] start_month;
		logic [4:0] start_day;
		logic [4:0] start_hour;
		logic [5:0] start_minute;
		logic [5:0] start_second;
	} res_word_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic diff;
		logic walk;
		logic hour;
		logic minute;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic ok;
		logic same_day;
		logic walk_end;
		logic ge_hour;
		logic ge_min;
	} dp_stat_t;

	// Length of a month in a common year; months outside 1..12 read as 31.
	function automatic logic [7:0] month_days(input logic [7:0] m);
		logic [7:0] len;
		case (m) inside
			8'd2:                    len = 8'd28;
			8'd4, 8'd6, 8'd9, 8'd11: len = 8'd30;
			default:                 len = 8'd31;
		endcase
		return len;
	endfunction

	// Every two-digit year maps to 1993..2092, where the century rule never
	// applies and 2000 is a leap year, so divisibility by four decides.
	function automatic logic is_leap(input logic [7:0] y);
		return (y[1:0] == 2'b00);
	endfunction

endpackage

>>> hdl/sdfd_req_if.sv
// Request channel: end date-time and duration with a valid/ready handshake.
interface sdfd_req_if;
	import sdfd_pkg::*;

	logic      valid;
	logic      ready;
	req_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/sdfd_res_if.sv
// Result channel: start date-time and valid flag with a valid/ready handshake.
interface sdfd_res_if;
	import sdfd_pkg::*;

	logic      valid;
	logic      ready;
	res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/start_datetime_from_duration.sv
// Top level: start date-time found by stepping back from an end date-time.
//
// A request word carries an end date-time (two-digit year, month, day, hour,
// minute, second) and a duration in seconds. The result word carries the
// start date-time that lies that many seconds earlier and a valid flag; on
// an invalid request the flag and every field are zero.
// One request is worked on at a time: request.ready is high only while the
// block is idle. After acceptance the controller works out the time of day
// and validation, then the difference, then steps back one calendar day at a
// time for a span that crosses midnight, then counts off hours and minutes.
// The result is held in an output register with result.valid high until
// result.ready takes it, and only then is the next request accepted, so a
// stalled receiver simply holds the block.
// Reset clears the controller to idle; no result is pending after it.
module start_datetime_from_duration (
	input logic      clk,
	input logic      arst_n,
	sdfd_req_if.sink request,
	sdfd_res_if.source result
);
	import sdfd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sdfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sdfd_dp u_dp (
		.clk  (clk),
		.req  (request.data),
		.cmd  (cmd),
		.stat (stat),
		.res  (result.data)
	);
endmodule

>>> hdl/sdfd_dp.sv
// Datapath: input capture, validation, day walk and time-of-day split.
module sdfd_dp (
	input  logic                clk,
	input  sdfd_pkg::req_word_t req,
	input  sdfd_pkg::dp_cmd_t   cmd,
	output sdfd_pkg::dp_stat_t  stat,
	output sdfd_pkg::res_word_t res
);
	import sdfd_pkg::*;

	logic [7:0]               year_q, month_q, day_q;
	logic [7:0]               hour_q, minute_q, second_q;
	logic [DURATION_BITS-1:0] dur_q;
	logic [DURATION_BITS-1:0] rem_q;
	logic [TOD_W-1:0]         tod_q;
	logic [TOD_W-1:0]         t_q;
	logic [4:0]               hcnt_q;
	logic [5:0]               mcnt_q;
	logic                     ok_q;
	res_word_t                res_q;

	logic [19:0]              tod_full;
	logic [7:0]               lim;
	logic                     in_ok;
	logic [DURATION_BITS-1:0] tod_ext;
	logic [DURATION_BITS-1:0] day_ext;
	logic [7:0]               prev_y, prev_m, prev_d;

	assign tod_full = 20'(hour_q) * 20'd3600 + 20'(minute_q) * 20'd60 + 20'(second_q);

	always_comb begin
		lim = month_days(month_q);
		if (month_q == FEBRUARY && is_leap(year_q)) begin
			lim = LEAP_FEB;
		end
		in_ok = (year_q <= MAX_YEAR) && (month_q != 8'd0) && (month_q <= MAX_MONTH)
			&& (day_q != 8'd0) && (day_q <= lim) && (hour_q <= MAX_HOUR)
			&& (minute_q <= MAX_MINSEC) && (second_q <= MAX_MINSEC) && (dur_q != '0);
	end

	// One day back, borrowing from the month and, in January, from the year.
	always_comb begin
		prev_y = year_q;
		prev_m = month_q;
		prev_d = day_q - 8'd1;
		if (day_q == 8'd1) begin
			prev_m = month_q - 8'd1;
			if (prev_m == 8'd0) begin
				prev_m = DECEMBER;
				prev_y = (year_q == 8'd0) ? MAX_YEAR : year_q - 8'd1;
			end
			prev_d = (prev_m == FEBRUARY && is_leap(year_q)) ? LEAP_FEB : month_days(prev_m);
		end
	end

	assign tod_ext = DURATION_BITS'(tod_q);
	assign day_ext = DURATION_BITS'(SECS_PER_DAY);

	assign stat.ok       = ok_q;
	assign stat.same_day = (tod_ext >= dur_q);
	assign stat.walk_end = (rem_q <= day_ext);
	assign stat.ge_hour  = (t_q >= SECS_PER_HOUR);
	assign stat.ge_min   = (t_q >= SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q   <= req.end_year;
			month_q  <= req.end_month;
			day_q    <= req.end_day;
			hour_q   <= req.end_hour;
			minute_q <= req.end_minute;
			second_q <= req.end_second;
			dur_q    <= req.duration_seconds[DURATION_BITS-1:0];
		end
		if (cmd.prep) begin
			tod_q <= tod_full[TOD_W-1:0];
			ok_q  <= in_ok;
		end
		if (cmd.diff) begin
			hcnt_q <= '0;
			mcnt_q <= '0;
			if (stat.same_day) begin
				t_q <= tod_q - dur_q[TOD_W-1:0];
			end else begin
				rem_q <= dur_q - tod_ext;
			end
		end
		if (cmd.walk) begin
			year_q  <= prev_y;
			month_q <= prev_m;
			day_q   <= prev_d;
			if (stat.walk_end) begin
				t_q <= SECS_PER_DAY - rem_q[TOD_W-1:0];
			end else begin
				rem_q <= rem_q - day_ext;
			end
		end
		if (cmd.hour) begin
			t_q    <= t_q - SECS_PER_HOUR;
			hcnt_q <= hcnt_q + 5'd1;
		end
		if (cmd.minute) begin
			t_q    <= t_q - SECS_PER_MIN;
			mcnt_q <= mcnt_q + 6'd1;
		end
		if (cmd.finish) begin
			if (ok_q) begin
				res_q.valid_res    <= 1'b1;
				res_q.start_year   <= year_q[6:0];
				res_q.start_month  <= month_q[3:0];
				res_q.start_day    <= day_q[4:0];
				res_q.start_hour   <= hcnt_q;
				res_q.start_minute <= mcnt_q;
				res_q.start_second <= t_q[5:0];
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res = res_q;
endmodule

>>> hdl/sdfd_ctrl.sv
// Controller: sequences capture, validation, day walk and time split.
module sdfd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               res_valid,
	input  logic               res_ready,
	input  sdfd_pkg::dp_stat_t stat,
	output sdfd_pkg::dp_cmd_t  cmd
);
	import sdfd_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PREP = 7'b0000010,
		S_DIFF = 7'b0000100,
		S_WALK = 7'b0001000,
		S_HOUR = 7'b0010000,
		S_MIN  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DIFF;
			end
			S_DIFF: begin
				if (!stat.ok) begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.diff = 1'b1;
					state_d  = stat.same_day ? S_HOUR : S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_end) begin
					state_d = S_HOUR;
				end
			end
			S_HOUR: begin
				if (stat.ge_hour) begin
					cmd.hour = 1'b1;
				end else begin
					state_d = S_MIN;
				end
			end
			S_MIN: begin
				if (stat.ge_min) begin
					cmd.minute = 1'b1;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
endmodule

>>> sim/start_datetime_from_duration_test.sv
// Self-checking testbench for the start date-time block: directed table, then random words.
`timescale 1ns / 1ps

module start_datetime_from_duration_test;
	import sdfd_pkg::*;

	localparam int unsigned PIVOT = 93;
	localparam int unsigned PROBE_COUNT = 24;
	localparam int unsigned RANDOM_COUNT = 76;
	localparam res_word_t NO_START = '0;

	typedef struct packed {
		req_word_t req;
		logic      typed;
		res_word_t want;
	} probe_row_t;

	// Rows with typed set carry a result that follows directly from the calendar;
	// the others are checked against the predictor.
	localparam probe_row_t PROBES [PROBE_COUNT] = '{
		'{'{8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 32'd1}, 1'b1,
			'{1'b1, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
		'{'{8'd24, 8'd6, 8'd15, 8'd12, 8'd30, 8'd45, 32'd45}, 1'b1,
			'{1'b1, 7'd24, 4'd6, 5'd15, 5'd12, 6'd30, 6'd0}},
		'{'{8'd24, 8'd6, 8'd15, 8'd10, 8'd0, 8'd0, 32'd36000}, 1'b1,
			'{1'b1, 7'd24, 4'd6, 5'd15, 5'd0, 6'd0, 6'd0}},
		'{'{8'd24, 8'd6, 8'd15, 8'd10, 8'd0, 8'd0, 32'd0}, 1'b1, NO_START},
		'{'{8'd100, 8'd6, 8'd15, 8'd10, 8'd0, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF}, 1'b1, NO_START},
		'{'{8'd24, 8'd0, 8'd15, 8'd10, 8'd0, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd24, 8'd13, 8'd15, 8'd10, 8'd0, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd24, 8'd6, 8'd0, 8'd10, 8'd0, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd23, 8'd4, 8'd31, 8'd10, 8'd0, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd23, 8'd2, 8'd29, 8'd10, 8'd0, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd24, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0, 32'd1}, 1'b1,
			'{1'b1, 7'd24, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59}},
		'{'{8'd24, 8'd6, 8'd15, 8'd24, 8'd0, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd24, 8'd6, 8'd15, 8'd10, 8'd60, 8'd0, 32'd1}, 1'b1, NO_START},
		'{'{8'd24, 8'd6, 8'd15, 8'd10, 8'd0, 8'd60, 32'd1}, 1'b1, NO_START},
		'{'{8'd24, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0, 32'd86400}, 1'b1,
			'{1'b1, 7'd24, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}},
		'{'{8'd93, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 32'd1}, 1'b1,
			'{1'b1, 7'd92, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
		'{'{8'd93, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 32'd172800}, 1'b0, NO_START},
		'{'{8'd0, 8'd3, 8'd1, 8'd12, 8'd0, 8'd0, 32'd5000000}, 1'b0, NO_START},
		'{'{8'd99, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 32'hFFFF_FFFF}, 1'b0, NO_START},
		'{'{8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF}, 1'b0, NO_START},
		'{'{8'd92, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 32'h8000_0000}, 1'b0, NO_START},
		'{'{8'd50, 8'd7, 8'd4, 8'd23, 8'd59, 8'd59, 32'd86399}, 1'b1,
			'{1'b1, 7'd50, 4'd7, 5'd4, 5'd0, 6'd0, 6'd0}},
		'{'{8'd0, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0, 32'd31622400}, 1'b0, NO_START}
	};

	logic clk = 1'b0;
	logic arst_n;

	sdfd_req_if req_ch ();
	sdfd_res_if res_ch ();

	start_datetime_from_duration uut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (res_ch)
	);

	res_word_t pending_starts [$];
	int unsigned mismatches = 0;
	bit calm = 1'b0;
	logic drv_typed;
	res_word_t drv_expect;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic bit gregorian_leap(input int unsigned fy);
		return ((fy % 4 == 0) && (fy % 100 != 0)) || (fy % 400 == 0);
	endfunction

	function automatic int unsigned century_year(input int unsigned yy);
		return (yy < PIVOT) ? yy + 2000 : yy + 1900;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned fy, input int unsigned mo);
		int unsigned len;
		case (mo)
			2:             len = gregorian_leap(fy) ? 29 : 28;
			4, 6, 9, 11:   len = 30;
			default:       len = 31;
		endcase
		return len;
	endfunction

	// Start date-time that lies the given number of seconds before the end date-time.
	function automatic res_word_t start_datetime(input req_word_t r);
		int unsigned yy, mo, dd, fy;
		longint unsigned dur, tod, t, diff, days, rem, i;
		res_word_t s;
		s = '0;
		yy = r.end_year;
		mo = r.end_month;
		dd = r.end_day;
		dur = 64'(r.duration_seconds) & ((64'd1 << DURATION_BITS) - 64'd1);
		if (yy > MAX_YEAR || mo < 1 || mo > MAX_MONTH || dd < 1)
			return s;
		if (dd > days_in_month(century_year(yy), mo))
			return s;
		if (r.end_hour > MAX_HOUR || r.end_minute > MAX_MINSEC || r.end_second > MAX_MINSEC ||
				dur == 0)
			return s;
		tod = 64'(r.end_hour) * 3600 + 64'(r.end_minute) * 60 + 64'(r.end_second);
		if (tod >= dur) begin
			t = tod - dur;
		end else begin
			diff = dur - tod;
			days = diff / 86400;
			rem = diff % 86400;
			if (days != 0 && rem == 0) begin
				days--;
				rem = 86400;
			end
			// Every step re-reads the two-digit year through the pivot, so a walk
			// out of 1993 carries on in 2092.
			for (i = 0; i <= days; i++) begin
				fy = century_year(yy);
				if (dd == 1) begin
					if (mo == 1) begin
						mo = 12;
						fy--;
					end else begin
						mo--;
					end
					dd = days_in_month(fy, mo);
				end else begin
					dd--;
				end
				yy = fy % 100;
			end
			t = 86400 - rem;
		end
		s.valid_res = 1'b1;
		s.start_year = 7'(yy);
		s.start_month = 4'(mo);
		s.start_day = 5'(dd);
		s.start_hour = 5'(t / 3600);
		s.start_minute = 6'((t % 3600) / 60);
		s.start_second = 6'(t % 60);
		return s;
	endfunction

	always @(posedge clk) begin : watch
		res_word_t want, got;
		if (res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (pending_starts.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word: %0d %0d-%0d-%0d %0d:%0d:%0d",
						got.valid_res, got.start_year, got.start_month, got.start_day,
						got.start_hour, got.start_minute, got.start_second);
				mismatches++;
			end else begin
				want = pending_starts.pop_front();
				if (got.valid_res !== want.valid_res || got.start_year !== want.start_year ||
						got.start_month !== want.start_month ||
						got.start_day !== want.start_day ||
						got.start_hour !== want.start_hour ||
						got.start_minute !== want.start_minute ||
						got.start_second !== want.start_second) begin
					if (mismatches < 10) begin
						$write("start mismatch at %0t: expected %0d %0d-%0d-%0d %0d:%0d:%0d",
							$realtime, want.valid_res, want.start_year, want.start_month,
							want.start_day, want.start_hour, want.start_minute,
							want.start_second);
						$display(", got %0d %0d-%0d-%0d %0d:%0d:%0d",
							got.valid_res, got.start_year,
							got.start_month, got.start_day, got.start_hour,
							got.start_minute, got.start_second);
					end
					mismatches++;
				end
			end
		end
		if (req_ch.valid && req_ch.ready)
			pending_starts.push_back(drv_typed ? drv_expect : start_datetime(req_ch.data));
	end

	// Receiving side; after twenty words it holds off long enough for the block to
	// back up onto its input.
	initial begin : result_taker
		int unsigned stall, taken;
		taken = 0;
		res_ch.ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 17);
			if (taken == 20)
				stall = 600;
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken++;
		end
	end

	task automatic offer_end(input req_word_t w, input logic typed, input res_word_t want);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		drv_typed <= typed;
		drv_expect <= want;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	initial begin : stimulus
		int unsigned k, yy, mo, dd, lim, tod, kind, field;
		logic [31:0] dur;
		req_word_t w;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		drv_typed <= 1'b0;
		drv_expect <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < PROBE_COUNT; k++)
			offer_end(PROBES[k].req, PROBES[k].typed, PROBES[k].want);

		// Let the block drain completely before the random words; the extra edge
		// makes sure the last accepted word is already queued.
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_starts.size() != 0)
			@(posedge clk);

		for (k = 0; k < RANDOM_COUNT; k++) begin
			calm = (k >= 40 && k < 60);
			kind = $urandom_range(0, 99);
			yy = $urandom_range(0, 99);
			mo = $urandom_range(1, 12);
			lim = days_in_month(century_year(yy), mo);
			dd = $urandom_range(1, lim);
			w.end_year = 8'(yy);
			w.end_month = 8'(mo);
			w.end_day = 8'(dd);
			w.end_hour = 8'($urandom_range(0, 23));
			w.end_minute = 8'($urandom_range(0, 59));
			w.end_second = 8'($urandom_range(0, 59));
			tod = w.end_hour * 3600 + w.end_minute * 60 + w.end_second;
			// Only a few words walk back the full span; the rest stay within about a year.
			if (k % 20 == 7) begin
				dur = $urandom;
				if (dur == 0)
					dur = 1;
			end else if (kind < 20) begin
				dur = $urandom_range(1, tod + 1);
			end else if (kind < 30) begin
				dur = tod + 86400 * $urandom_range(1, 40);
			end else if (kind < 50) begin
				dur = $urandom_range(1, 3 * 86400);
			end else begin
				dur = $urandom_range(1, 400 * 86400);
			end
			w.duration_seconds = dur;
			if (kind >= 88) begin
				w.end_year = 8'($urandom_range(0, 255));
				w.end_month = 8'($urandom_range(0, 255));
				w.end_day = 8'($urandom_range(0, 255));
				w.end_hour = 8'($urandom_range(0, 255));
				w.end_minute = 8'($urandom_range(0, 255));
				w.end_second = 8'($urandom_range(0, 255));
				w.duration_seconds = ($urandom_range(0, 3) == 0) ? 32'd0 :
					32'($urandom_range(1, 400 * 86400));
			end else if (kind >= 80) begin
				// One field pushed out of range.
				field = $urandom_range(0, 6);
				case (field)
					0: w.end_year = 8'($urandom_range(100, 255));
					1: w.end_month = ($urandom_range(0, 1) != 0) ? 8'd0 :
						8'($urandom_range(13, 255));
					2: w.end_day = ($urandom_range(0, 1) != 0) ? 8'd0 :
						8'($urandom_range(lim + 1, 255));
					3: w.end_hour = 8'($urandom_range(24, 255));
					4: w.end_minute = 8'($urandom_range(60, 255));
					5: w.end_second = 8'($urandom_range(60, 255));
					default: w.duration_seconds = '0;
				endcase
			end
			offer_end(w, 1'b0, NO_START);
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending_starts.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_starts.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> start_datetime_from_duration.f
hdl/sdfd_pkg.sv
hdl/sdfd_req_if.sv
hdl/sdfd_res_if.sv
hdl/sdfd_dp.sv
hdl/sdfd_ctrl.sv
hdl/start_datetime_from_duration.sv
sim/start_datetime_from_duration_test.sv
